### hw/rtl/record_list_table_engine_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the record list table engine.
// ---------------------------------------------------------------------------
`ifndef RECORD_LIST_TABLE_ENGINE_TOP_ASSERT_SVH
`define RECORD_LIST_TABLE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RLTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rlte_pkg.sv
// ---------------------------------------------------------------------------
// rlte_pkg
// Types and constants shared by the record list table engine.
// ---------------------------------------------------------------------------
package rlte_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int NAME_BYTES_DEF = 8;
    localparam int MAX_RESULTS    = 32;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_SORT   = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NF    = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic [63:0]        item_name;
        logic signed [31:0] item_amount;
        logic [4:0]         item_index;
    } req_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         found_index;
        logic [63:0]        out_name;
        logic signed [31:0] out_amount;
        logic               last;
    } rsp_word_t;

endpackage

### hw/rtl/rlte_store.sv
// ---------------------------------------------------------------------------
// rlte_store
// Record memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module rlte_store
    import rlte_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [8*NAME_BYTES-1:0]       wr_name,
    input  logic signed [31:0]            wr_amount,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [8*NAME_BYTES-1:0]       rd_name,
    output logic signed [31:0]            rd_amount
);

    localparam int NAME_W = 8 * NAME_BYTES;

    logic [NAME_W-1:0]  name_mem [DEPTH];
    logic signed [31:0] amount_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            name_mem[waddr]   <= wr_name;
            amount_mem[waddr] <= wr_amount;
        end
        if (rd_en)
        begin
            rd_name   <= name_mem[raddr];
            rd_amount <= amount_mem[raddr];
        end
    end

endmodule

### hw/rtl/rlte_cmp.sv
// ---------------------------------------------------------------------------
// rlte_cmp
// Shared name comparator: full-key equality and first-byte ordering.
// ---------------------------------------------------------------------------
module rlte_cmp
    import rlte_pkg::*;
#(
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic [8*NAME_BYTES-1:0] a_name,
    input  logic [8*NAME_BYTES-1:0] b_name,
    output logic                    eq,
    output logic                    gt
);

    localparam int NAME_W = 8 * NAME_BYTES;

    assign eq = (a_name == b_name);
    // sort key is the first character only, unsigned
    assign gt = (a_name[NAME_W-1 -: 8] > b_name[NAME_W-1 -: 8]);

endmodule

### hw/rtl/rlte_core.sv
// ---------------------------------------------------------------------------
// rlte_core
// Sequencer: walks the record memory for lookup, remove, sort and list
// operations and holds the output register.
// ---------------------------------------------------------------------------
module rlte_core
    import rlte_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  req_word_t                          req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output rsp_word_t                          rsp,
    output logic [$clog2(DEPTH+1)-1:0]         used,
    output logic                               wr_en,
    output logic [$clog2(DEPTH)-1:0]           waddr,
    output logic [8*NAME_BYTES-1:0]            wr_name,
    output logic signed [31:0]                 wr_amount,
    output logic                               rd_en,
    output logic [$clog2(DEPTH)-1:0]           raddr,
    input  logic [8*NAME_BYTES-1:0]            rd_name,
    input  logic signed [31:0]                 rd_amount,
    output logic [8*NAME_BYTES-1:0]            cmp_a,
    output logic [8*NAME_BYTES-1:0]            cmp_b,
    input  logic                               cmp_eq,
    input  logic                               cmp_gt
);

    localparam int NAME_W   = 8 * NAME_BYTES;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int LIST_MAX = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LK_CMP  = 9'b000000010,
        S_LS_CAP  = 9'b000000100,
        S_RM_CAP  = 9'b000001000,
        S_RM_WR   = 9'b000010000,
        S_ST_LOAD = 9'b000100000,
        S_ST_CMP  = 9'b001000000,
        S_ST_END  = 9'b010000000,
        S_EMIT    = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   idx;
        logic [NAME_W-1:0]  name;
        logic signed [31:0] amount;
        logic               last;
    } res_t;

    function automatic res_t mk_res(logic [1:0] status, logic [IDX_W-1:0] idx,
                                    logic [NAME_W-1:0] name,
                                    logic signed [31:0] amount, logic last);
        res_t r;
        r.status = status;
        r.idx    = idx;
        r.name   = name;
        r.amount = amount;
        r.last   = last;
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [NAME_W-1:0]  key_reg, key_next;
    logic [NAME_W-1:0]  hold_name_reg, hold_name_next;
    logic signed [31:0] hold_amt_reg, hold_amt_next;
    logic               swap_reg, swap_next;
    res_t               res_reg, res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_word_t          rsp_reg, rsp_next;

    logic [CNT_W-1:0]   ptr_p1, ptr_p2, ptr_m1, list_n;
    logic [NAME_W-1:0]  req_key;
    logic               can_push;

    assign ptr_p1  = ptr_reg + CNT_W'(1);
    assign ptr_p2  = ptr_reg + CNT_W'(2);
    assign ptr_m1  = ptr_reg - CNT_W'(1);
    assign list_n  = (cnt_reg > CNT_W'(LIST_MAX)) ? CNT_W'(LIST_MAX) : cnt_reg;
    assign req_key = req.item_name[63 -: NAME_W];
    assign can_push = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign used      = cnt_reg;

    assign cmp_a = (state_reg == S_LK_CMP) ? key_reg : hold_name_reg;
    assign cmp_b = rd_name;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        key_next       = key_reg;
        hold_name_next = hold_name_reg;
        hold_amt_next  = hold_amt_reg;
        swap_next      = swap_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        waddr          = '0;
        wr_name        = '0;
        wr_amount      = '0;
        rd_en          = 1'b0;
        raddr          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EMIT;
                    case (req.op)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                res_next = mk_res(ST_FULL, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                waddr     = IDX_W'(cnt_reg);
                                wr_name   = req_key;
                                wr_amount = req.item_amount;
                                res_next  = mk_res(ST_OK, IDX_W'(cnt_reg), req_key,
                                                   req.item_amount, 1'b1);
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next = mk_res(ST_NF, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                key_next   = req_key;
                                rd_en      = 1'b1;
                                ptr_next   = '0;
                                state_next = S_LK_CMP;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (7'(req.item_index) >= 7'(cnt_reg))
                            begin
                                res_next = mk_res(ST_RANGE, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                raddr      = IDX_W'(req.item_index);
                                ptr_next   = CNT_W'(req.item_index);
                                state_next = S_RM_CAP;
                            end
                        end
                        OP_SORT:
                        begin
                            if (cnt_reg < CNT_W'(2))
                            begin
                                res_next = mk_res(ST_OK, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_ST_LOAD;
                            end
                        end
                        OP_LIST:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next = mk_res(ST_NF, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                ptr_next   = '0;
                                state_next = S_LS_CAP;
                            end
                        end
                        default:
                        begin
                            res_next = mk_res(ST_NF, '0, '0, '0, 1'b1);
                        end
                    endcase
                end
            end

            // read data belongs to entry ptr; next read goes out alongside
            S_LK_CMP:
            begin
                if (cmp_eq)
                begin
                    res_next   = mk_res(ST_OK, IDX_W'(ptr_reg), rd_name, rd_amount, 1'b1);
                    state_next = S_EMIT;
                end
                else if (ptr_p1 == cnt_reg)
                begin
                    res_next   = mk_res(ST_NF, '0, '0, '0, 1'b1);
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    raddr    = IDX_W'(ptr_p1);
                    ptr_next = ptr_p1;
                end
            end

            S_LS_CAP:
            begin
                res_next   = mk_res(ST_OK, IDX_W'(ptr_reg), rd_name, rd_amount,
                                    ptr_p1 == list_n);
                state_next = S_EMIT;
            end

            S_RM_CAP:
            begin
                res_next = mk_res(ST_OK, IDX_W'(ptr_reg), rd_name, rd_amount, 1'b1);
                if (ptr_p1 < cnt_reg)
                begin
                    rd_en      = 1'b1;
                    raddr      = IDX_W'(ptr_p1);
                    state_next = S_RM_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
            end

            // move entry ptr+1 down to ptr, fetch the one after
            S_RM_WR:
            begin
                wr_en     = 1'b1;
                waddr     = IDX_W'(ptr_reg);
                wr_name   = rd_name;
                wr_amount = rd_amount;
                ptr_next  = ptr_p1;
                if (ptr_p2 < cnt_reg)
                begin
                    rd_en = 1'b1;
                    raddr = IDX_W'(ptr_p2);
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
            end

            S_ST_LOAD:
            begin
                hold_name_next = rd_name;
                hold_amt_next  = rd_amount;
                swap_next      = 1'b0;
                ptr_next       = CNT_W'(1);
                rd_en          = 1'b1;
                raddr          = IDX_W'(1);
                state_next     = S_ST_CMP;
            end

            // bubble pass: the larger record rides along in hold
            S_ST_CMP:
            begin
                wr_en = 1'b1;
                waddr = IDX_W'(ptr_m1);
                if (cmp_gt)
                begin
                    wr_name   = rd_name;
                    wr_amount = rd_amount;
                    swap_next = 1'b1;
                end
                else
                begin
                    wr_name        = hold_name_reg;
                    wr_amount      = hold_amt_reg;
                    hold_name_next = rd_name;
                    hold_amt_next  = rd_amount;
                end
                if (ptr_p1 < cnt_reg)
                begin
                    rd_en    = 1'b1;
                    raddr    = IDX_W'(ptr_p1);
                    ptr_next = ptr_p1;
                end
                else
                begin
                    state_next = S_ST_END;
                end
            end

            S_ST_END:
            begin
                wr_en     = 1'b1;
                waddr     = IDX_W'(cnt_reg - CNT_W'(1));
                wr_name   = hold_name_reg;
                wr_amount = hold_amt_reg;
                if (swap_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_ST_LOAD;
                end
                else
                begin
                    res_next   = mk_res(ST_OK, '0, '0, '0, 1'b1);
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (can_push)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = res_reg.status;
                    rsp_next.found_index = 5'(res_reg.idx);
                    rsp_next.out_name    = 64'(res_reg.name) << (64 - NAME_W);
                    rsp_next.out_amount  = res_reg.amount;
                    rsp_next.last        = res_reg.last;
                    if (res_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        raddr      = IDX_W'(ptr_p1);
                        ptr_next   = ptr_p1;
                        state_next = S_LS_CAP;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        key_reg       <= key_next;
        hold_name_reg <= hold_name_next;
        hold_amt_reg  <= hold_amt_next;
        swap_reg      <= swap_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

endmodule

### hw/rtl/record_list_table_engine_top.sv
// ---------------------------------------------------------------------------
// record_list_table_engine_top
// Bounded record list: insert, lookup, remove, sort and list operations.
// ---------------------------------------------------------------------------
// Usage:
//   req channel carries one operation word (req_valid / req_stall); the
//   engine holds req_stall high while it works on a word, so one word is in
//   flight at a time. rsp channel returns result words (rsp_valid /
//   rsp_stall); list gives one word per record (at most MAX_RESULTS), last set on the final one.
//   Insert, bad op and range error take no memory walk; lookup scans from
//   entry 0 to the first match; remove at index k shifts entries k+1..n-1
//   down (n = records held); sort runs up to n bubble passes, stopping after
//   one without a swap; list reads one record per result word.
//   Each step uses at most one write and one read of the single-write,
//   single-read record memory; sort and lookup share one name comparator.
//   The result register frees the sequencer as soon as rsp takes a word; a
//   stalled rsp holds its word and the sequencer waits on the next result.
//   Reset empties the list; memory contents are not cleared.
// ---------------------------------------------------------------------------
`include "record_list_table_engine_top_assert.svh"

module record_list_table_engine_top
    import rlte_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam int NAME_W = 8 * NAME_BYTES;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]   used;
    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   waddr, raddr;
    logic [NAME_W-1:0]  wr_name, rd_name;
    logic signed [31:0] wr_amount, rd_amount;
    logic [NAME_W-1:0]  cmp_a, cmp_b;
    logic               cmp_eq, cmp_gt;

    rlte_core #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .used      (used),
        .wr_en     (wr_en),
        .waddr     (waddr),
        .wr_name   (wr_name),
        .wr_amount (wr_amount),
        .rd_en     (rd_en),
        .raddr     (raddr),
        .rd_name   (rd_name),
        .rd_amount (rd_amount),
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp_eq    (cmp_eq),
        .cmp_gt    (cmp_gt)
    );

    rlte_store #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .waddr     (waddr),
        .wr_name   (wr_name),
        .wr_amount (wr_amount),
        .rd_en     (rd_en),
        .raddr     (raddr),
        .rd_name   (rd_name),
        .rd_amount (rd_amount)
    );

    rlte_cmp #(
        .NAME_BYTES (NAME_BYTES)
    ) u_cmp (
        .a_name (cmp_a),
        .b_name (cmp_b),
        .eq     (cmp_eq),
        .gt     (cmp_gt)
    );

    `RLTE_ASSERT_NOW(a_count_bound, 1'b1, used <= CNT_W'(DEPTH), "record count past depth")
    `RLTE_ASSERT_NEXT(a_insert_count,
        req_valid && !req_stall && req.op == OP_INSERT && used != CNT_W'(DEPTH),
        used == $past(used) + CNT_W'(1), "insert did not grow list")
    `RLTE_ASSERT_NOW(a_mid_list_ok, rsp_valid && !rsp.last, rsp.status == ST_OK,
        "non-final word not ok")

endmodule

### test/record_list_table_engine_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// record_list_table_engine_top_tb
// Self-checking bench for the record list engine. Operation words go in
// through a shared send task, and a shadow list predicts every result word.
// A monitor compares each word taken from rsp against the oldest predicted
// word. Both channels idle at random, except during one steady stretch.
// ---------------------------------------------------------------------------
module record_list_table_engine_top_tb;
    import rlte_pkg::*;

    localparam int          DEPTH      = DEPTH_DEF;
    localparam int          NAME_BYTES = NAME_BYTES_DEF;
    localparam logic [2:0]  OP_SPARE_5 = 3'd5;
    localparam logic [2:0]  OP_SPARE_6 = 3'd6;
    localparam logic [2:0]  OP_SPARE_7 = 3'd7;
    localparam int          IDLE_PCT   = 27;
    localparam int          MAX_PRINTS = 60;
    localparam logic [63:0] NAME_MASK  = (NAME_BYTES >= 8) ? {64{1'b1}} :
                                         ~((64'd1 << (64 - 8 * NAME_BYTES)) - 64'd1);
    localparam logic [63:0] NM_ALICE   = {"ALICE", 24'd0};
    localparam logic [63:0] NM_BETTY   = {"BETTY", 24'd0};
    localparam logic [63:0] NM_BOB     = {"BOB", 40'd0};
    localparam logic [63:0] NM_ZED     = {"ZED", 40'd0};

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;
    logic      steady    = 1'b0;

    // shadow copy of the list
    logic [63:0] shadow_names   [DEPTH];
    logic [31:0] shadow_amounts [DEPTH];
    int          shadow_count = 0;
    rsp_word_t   due_words [$];
    int          err_count = 0;

    record_list_table_engine_top #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    task report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_field(input string field, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
    endtask

    task push_due(input logic [1:0] st, input int idx, input logic [63:0] nm,
                  input logic [31:0] am, input logic lst);
        rsp_word_t w;
        w.status      = st;
        w.found_index = 5'(idx);
        w.out_name    = nm;
        w.out_amount  = am;
        w.last        = lst;
        due_words.push_back(w);
    endtask

    // Applies one accepted word to the shadow list and queues its results.
    task shadow_apply(input req_word_t w);
        logic [63:0] nm;
        logic [31:0] am;
        logic [63:0] tn;
        logic [31:0] ta;
        int          n;
        int          hit;
        int          idx;
        int          m;
        nm  = w.item_name & NAME_MASK;
        am  = w.item_amount;
        n   = shadow_count;
        idx = int'(w.item_index);
        case (w.op)
            OP_INSERT:
            begin
                if (n >= DEPTH)
                    push_due(ST_FULL, 0, '0, '0, 1'b1);
                else
                begin
                    shadow_names[n]   = nm;
                    shadow_amounts[n] = am;
                    push_due(ST_OK, n, nm, am, 1'b1);
                    shadow_count++;
                end
            end
            OP_LOOKUP:
            begin
                hit = -1;
                for (int i = 0; i < n; i++)
                    if (hit < 0 && shadow_names[i] == nm)
                        hit = i;
                if (hit < 0)
                    push_due(ST_NF, 0, '0, '0, 1'b1);
                else
                    push_due(ST_OK, hit, shadow_names[hit], shadow_amounts[hit], 1'b1);
            end
            OP_REMOVE:
            begin
                if (idx >= n)
                    push_due(ST_RANGE, 0, '0, '0, 1'b1);
                else
                begin
                    push_due(ST_OK, idx, shadow_names[idx], shadow_amounts[idx], 1'b1);
                    for (int i = idx; i + 1 < n; i++)
                    begin
                        shadow_names[i]   = shadow_names[i + 1];
                        shadow_amounts[i] = shadow_amounts[i + 1];
                    end
                    shadow_count--;
                end
            end
            OP_SORT:
            begin
                // stable: only a strictly larger first byte moves up
                for (int i = 0; i < n; i++)
                    for (int j = 0; j + 1 < n; j++)
                        if (shadow_names[j][63:56] > shadow_names[j + 1][63:56])
                        begin
                            tn                    = shadow_names[j];
                            ta                    = shadow_amounts[j];
                            shadow_names[j]       = shadow_names[j + 1];
                            shadow_amounts[j]     = shadow_amounts[j + 1];
                            shadow_names[j + 1]   = tn;
                            shadow_amounts[j + 1] = ta;
                        end
                push_due(ST_OK, 0, '0, '0, 1'b1);
            end
            OP_LIST:
            begin
                m = (n > MAX_RESULTS) ? MAX_RESULTS : n;
                if (m == 0)
                    push_due(ST_NF, 0, '0, '0, 1'b1);
                else
                    for (int i = 0; i < m; i++)
                        push_due(ST_OK, i, shadow_names[i], shadow_amounts[i], i + 1 == m);
            end
            default:
                push_due(ST_NF, 0, '0, '0, 1'b1);
        endcase
    endtask

    // result monitor
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (due_words.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want = due_words.pop_front();
                check_field("status", rsp.status, want.status);
                check_field("found_index", rsp.found_index, want.found_index);
                check_field("out_name", rsp.out_name, want.out_name);
                check_field("out_amount", rsp.out_amount, want.out_amount);
                check_field("last", rsp.last, want.last);
            end
        end
    end

    // Call on a rising edge; returns on a rising edge after the word is taken.
    task send_word(input req_word_t w);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        shadow_apply(w);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic req_word_t make_word(input logic [2:0] op, input logic [63:0] nm,
                                            input logic [31:0] am, input logic [4:0] idx);
        req_word_t w;
        w.op          = op;
        w.item_name   = nm;
        w.item_amount = am;
        w.item_index  = idx;
        return w;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mix of random keys, keys sharing one of six first bytes, and duplicates.
    function automatic logic [63:0] pick_name();
        int         roll;
        logic [7:0] lead;
        roll = $urandom_range(99);
        if (roll < 40 || (roll >= 80 && shadow_count == 0))
            return rand64();
        if (roll < 80)
        begin
            case ($urandom_range(5))
                0:       lead = "A";
                1:       lead = "B";
                2:       lead = "C";
                3:       lead = "D";
                4:       lead = 8'h00;
                default: lead = 8'hFF;
            endcase
            return {lead, 56'(rand64())};
        end
        return shadow_names[$urandom_range(shadow_count - 1)];
    endfunction

    // Lookup key: mostly a stored key, sometimes one bit off, sometimes fresh.
    function automatic logic [63:0] probe_name();
        int roll;
        roll = $urandom_range(99);
        if (shadow_count == 0 || roll >= 85)
            return pick_name();
        if (roll < 70)
            return shadow_names[$urandom_range(shadow_count - 1)];
        return shadow_names[$urandom_range(shadow_count - 1)] ^ (64'd1 << $urandom_range(63));
    endfunction

    function automatic req_word_t random_word();
        int          roll;
        int          ins_w;
        logic [2:0]  op;
        logic [63:0] nm;
        logic [4:0]  idx;
        // near full, removes take over part of the insert share
        ins_w = (shadow_count < DEPTH - 4) ? 36 : 14;
        roll  = $urandom_range(99);
        nm    = rand64();
        idx   = 5'($urandom);
        if (roll < ins_w)
        begin
            op = OP_INSERT;
            nm = pick_name();
        end
        else if (roll < ins_w + 22)
        begin
            op = OP_LOOKUP;
            nm = probe_name();
        end
        else if (roll < 78)
        begin
            op = OP_REMOVE;
            if (shadow_count > 0 && $urandom_range(99) < 80)
                idx = 5'($urandom_range(shadow_count - 1));
        end
        else if (roll < 84)
            op = OP_SORT;
        else if (roll < 94)
            op = OP_LIST;
        else
            op = 3'(OP_SPARE_5 + $urandom_range(2));
        return make_word(op, nm, $urandom, idx);
    endfunction

    task test_empty_list();
        send_word(make_word(OP_LIST, rand64(), $urandom, 5'd0));
        send_word(make_word(OP_LOOKUP, 64'd0, $urandom, 5'd0));
        send_word(make_word(OP_REMOVE, rand64(), $urandom, 5'd0));
        send_word(make_word(OP_REMOVE, rand64(), $urandom, 5'd31));
        send_word(make_word(OP_SORT, rand64(), $urandom, 5'($urandom)));
        send_word(make_word(OP_SPARE_5, rand64(), $urandom, 5'($urandom)));
        send_word(make_word(OP_SPARE_6, {64{1'b1}}, 32'hFFFF_FFFF, 5'd31));
        send_word(make_word(OP_SPARE_7, rand64(), $urandom, 5'($urandom)));
    endtask

    task test_basic_ops();
        send_word(make_word(OP_INSERT, {64{1'b1}}, 32'h7FFF_FFFF, 5'd31));
        send_word(make_word(OP_INSERT, 64'd0, 32'h8000_0000, 5'd0));
        send_word(make_word(OP_INSERT, NM_BOB, 32'hFFFF_FFFF, 5'($urandom)));
        send_word(make_word(OP_INSERT, NM_ALICE, 32'd0, 5'($urandom)));
        send_word(make_word(OP_INSERT, NM_BETTY, 32'd100, 5'($urandom)));
        send_word(make_word(OP_INSERT, NM_ALICE, 32'd5, 5'($urandom)));
        // duplicate key: first match wins
        send_word(make_word(OP_LOOKUP, NM_ALICE, $urandom, 5'($urandom)));
        send_word(make_word(OP_LOOKUP, 64'd0, $urandom, 5'($urandom)));
        send_word(make_word(OP_LOOKUP, NM_ZED, $urandom, 5'($urandom)));
        // index equal to the count, then the top index
        send_word(make_word(OP_REMOVE, rand64(), $urandom, 5'd6));
        send_word(make_word(OP_REMOVE, rand64(), $urandom, 5'd31));
        // ties on first byte must keep their order
        send_word(make_word(OP_SORT, rand64(), $urandom, 5'($urandom)));
        send_word(make_word(OP_LIST, rand64(), $urandom, 5'($urandom)));
        send_word(make_word(OP_REMOVE, rand64(), $urandom, 5'd0));
        send_word(make_word(OP_REMOVE, rand64(), $urandom, 5'(shadow_count - 1)));
        send_word(make_word(OP_LIST, rand64(), $urandom, 5'($urandom)));
    endtask

    task test_fill_and_overflow();
        while (shadow_count < DEPTH)
            send_word(make_word(OP_INSERT, pick_name(), $urandom, 5'($urandom)));
        send_word(make_word(OP_INSERT, pick_name(), $urandom, 5'($urandom)));
        send_word(make_word(OP_INSERT, {64{1'b1}}, 32'h7FFF_FFFF, 5'd31));
        send_word(make_word(OP_LOOKUP, shadow_names[DEPTH - 1], $urandom, 5'($urandom)));
        send_word(make_word(OP_LIST, rand64(), $urandom, 5'($urandom)));
        send_word(make_word(OP_SORT, rand64(), $urandom, 5'($urandom)));
        send_word(make_word(OP_LIST, rand64(), $urandom, 5'($urandom)));
        send_word(make_word(OP_REMOVE, rand64(), $urandom, 5'd31));
        send_word(make_word(OP_REMOVE, rand64(), $urandom, 5'd31));
        send_word(make_word(OP_INSERT, pick_name(), $urandom, 5'($urandom)));
        send_word(make_word(OP_LIST, rand64(), $urandom, 5'($urandom)));
    endtask

    task test_random_mix(input int count);
        for (int k = 0; k < count; k++)
            send_word(random_word());
    endtask

    // No idling on either side: drain the list, then random traffic.
    task test_steady_stream(input int count);
        steady <= 1'b1;
        while (shadow_count > 0)
            send_word(make_word(OP_REMOVE, rand64(), $urandom,
                                5'($urandom_range(shadow_count - 1))));
        send_word(make_word(OP_LIST, rand64(), $urandom, 5'($urandom)));
        for (int k = 0; k < count; k++)
            send_word(random_word());
        steady <= 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_basic_ops();
        test_fill_and_overflow();
        test_random_mix(300);
        test_steady_stream(30);
        req_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #(64'd20_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

### record_list_table_engine_top.f
+incdir+hw/rtl
hw/rtl/rlte_pkg.sv
hw/rtl/rlte_store.sv
hw/rtl/rlte_cmp.sv
hw/rtl/rlte_core.sv
hw/rtl/record_list_table_engine_top.sv
test/record_list_table_engine_top_tb.sv
